// File: rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Shared assertion shorthands, clocked on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds at every edge.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition at one edge implies a result at the next.
`define ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

// File: rtl/dtpc_pkg.sv
// ----------------------------------------------------------------------------
// dtpc_pkg
// Types and constants shared by the depth to point cloud block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dtpc_pkg;

  // Width in bits of the widest supported pixel coordinate.
  localparam int COORD_MAX = 13;
  localparam int DIFF_W    = 16;
  localparam int PROD1_W   = 32;
  localparam int PROD2_W   = 58;
  localparam int Q_DEPTH   = 4;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 25;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_X_HALF = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y_HALF = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INV_FOCAL_X   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_INV_FOCAL_Y   = 3'd5;

  typedef struct packed {
    logic [15:0] depth_mm;
    logic [7:0]  blue;
    logic [7:0]  green;
    logic [7:0]  red;
    logic        frame_start;
  } pixel_t;

  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic [15:0]        point_z;
    logic [7:0]         out_red;
    logic [7:0]         out_green;
    logic [7:0]         out_blue;
    logic               point_valid;
    logic               frame_end;
  } point_t;

  typedef struct packed {
    logic [12:0] frame_width;
    logic [12:0] frame_height;
    logic [12:0] center_x_half;
    logic [12:0] center_y_half;
    logic [24:0] inv_focal_x;
    logic [24:0] inv_focal_y;
  } cfg_t;

  typedef struct packed {
    logic [15:0] depth_mm;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic        point_valid;
    logic        frame_end;
  } tag_t;

  typedef struct packed {
    logic [COORD_MAX-1:0] col;
    logic [COORD_MAX-1:0] row;
    tag_t                 tag;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // Round half up at bit 25 (floor of t / 2^25) and saturate to 32 bits.
  function automatic logic signed [31:0] round_sat(input logic signed [PROD2_W-1:0] p);
    logic signed [PROD2_W-1:0] t;
    logic signed [32:0]        q;
    t = p + PROD2_W'(64'sd16777216);
    q = t[57:25];
    if (q[32] != q[31]) begin
      round_sat = q[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      round_sat = q[31:0];
    end
  endfunction

endpackage

// File: rtl/dtpc_front.sv
// ----------------------------------------------------------------------------
// dtpc_front
// Pixel intake: raster counters, frame end detection and job queuing.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module dtpc_front #(
  parameter int COORD_BITS = 12
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                pix_valid,
  output logic                pix_stall,
  input  dtpc_pkg::pixel_t    pix,
  input  dtpc_pkg::cfg_t      cfg,
  input  dtpc_pkg::q_status_t q_status,
  output logic                push,
  output dtpc_pkg::job_t      push_job
);

  localparam int SW = COORD_BITS + 1;
  localparam logic [dtpc_pkg::COORD_MAX:0] LIM = (dtpc_pkg::COORD_MAX+1)'(1 << COORD_BITS);

  logic [COORD_BITS-1:0] column_count, column_count_next;
  logic [COORD_BITS-1:0] row_count, row_count_next;
  logic [COORD_BITS-1:0] col, row;
  logic [SW-1:0]         col_inc, row_inc, w_eff, h_eff;
  logic [dtpc_pkg::COORD_MAX:0] w_wide, h_wide, w_clamp, h_clamp;
  logic                  fire, last, keep;

  assign w_wide  = {1'b0, cfg.frame_width};
  assign h_wide  = {1'b0, cfg.frame_height};
  assign w_clamp = (w_wide == '0) ? (dtpc_pkg::COORD_MAX+1)'(1) : ((w_wide > LIM) ? LIM : w_wide);
  assign h_clamp = (h_wide == '0) ? (dtpc_pkg::COORD_MAX+1)'(1) : ((h_wide > LIM) ? LIM : h_wide);
  assign w_eff   = w_clamp[SW-1:0];
  assign h_eff   = h_clamp[SW-1:0];

  assign col     = pix.frame_start ? '0 : column_count;
  assign row     = pix.frame_start ? '0 : row_count;
  assign col_inc = {1'b0, col} + SW'(1);
  assign row_inc = {1'b0, row} + SW'(1);
  assign last    = (col_inc == w_eff) && (row_inc == h_eff);
  assign keep    = (pix.depth_mm != '0) || last;

  assign pix_stall = q_status.full;
  assign fire      = pix_valid && !pix_stall;
  assign push      = fire && keep;

  always_comb begin
    if (col_inc >= w_eff) begin
      column_count_next = '0;
      row_count_next    = (row_inc >= h_eff) ? '0 : row_inc[COORD_BITS-1:0];
    end else begin
      column_count_next = col_inc[COORD_BITS-1:0];
      row_count_next    = row;
    end
  end

  always_comb begin
    push_job                 = '0;
    push_job.col             = dtpc_pkg::COORD_MAX'(col);
    push_job.row             = dtpc_pkg::COORD_MAX'(row);
    push_job.tag.depth_mm    = pix.depth_mm;
    push_job.tag.red         = pix.red;
    push_job.tag.green       = pix.green;
    push_job.tag.blue        = pix.blue;
    push_job.tag.point_valid = pix.depth_mm != '0;
    push_job.tag.frame_end   = last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (fire) begin
      column_count <= column_count_next;
      row_count    <= row_count_next;
    end
  end

  `ASSERT_NEXT(a_frame_wrap, fire && last, (column_count == '0) && (row_count == '0),
               "counters did not wrap after last pixel")
  `ASSERT_ALWAYS(a_push_kept, push |-> (push_job.tag.point_valid || push_job.tag.frame_end),
                 "queued a pixel that yields no result")

endmodule

// File: rtl/dtpc_queue.sv
// ----------------------------------------------------------------------------
// dtpc_queue
// Short job queue decoupling pixel intake from projection.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module dtpc_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  dtpc_pkg::job_t      push_job,
  input  logic                pop,
  output dtpc_pkg::job_t      pop_job,
  output dtpc_pkg::q_status_t status
);

  localparam int PTR_W = $clog2(dtpc_pkg::Q_DEPTH);

  dtpc_pkg::job_t     mem [dtpc_pkg::Q_DEPTH];
  logic [PTR_W-1:0]   wr_ptr, rd_ptr;
  logic [PTR_W:0]     count, count_next;
  logic               do_push, do_pop;

  assign status.full  = count == (PTR_W+1)'(dtpc_pkg::Q_DEPTH);
  assign status.empty = count == '0;
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign pop_job      = mem[rd_ptr];

  always_comb begin
    count_next = count;
    if (do_push && !do_pop) begin
      count_next = count + (PTR_W+1)'(1);
    end else if (do_pop && !do_push) begin
      count_next = count - (PTR_W+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      count <= count_next;
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(dtpc_pkg::Q_DEPTH-1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(dtpc_pkg::Q_DEPTH-1)) ? '0 : rd_ptr + PTR_W'(1);
      end
    end
  end

  `ASSERT_ALWAYS(a_count_bound, count <= (PTR_W+1)'(dtpc_pkg::Q_DEPTH),
                 "queue count beyond depth")
  `ASSERT_NEXT(a_pop_drains, do_pop && !do_push, count == $past(count) - (PTR_W+1)'(1),
               "pop did not reduce count")

endmodule

// File: rtl/dtpc_back.sv
// ----------------------------------------------------------------------------
// dtpc_back
// Three stage back-projection: offset times depth, times inverse focal
// length, then rounding, saturation and the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module dtpc_back (
  input  logic                clk,
  input  logic                rst,
  input  dtpc_pkg::cfg_t      cfg,
  input  dtpc_pkg::q_status_t q_status,
  input  dtpc_pkg::job_t      job,
  output logic                pop,
  output logic                pt_valid,
  input  logic                pt_stall,
  output dtpc_pkg::point_t    pt
);

  logic                                 adv;
  logic                                 va, vb;
  dtpc_pkg::tag_t                       ta, tb;
  logic signed [dtpc_pkg::DIFF_W-1:0]   dx, dy;
  logic signed [dtpc_pkg::PROD1_W-1:0]  p1x, p1y;
  logic signed [dtpc_pkg::PROD2_W-1:0]  p2x, p2y;
  dtpc_pkg::point_t                     pt_next;

  assign adv = !pt_valid || !pt_stall;
  assign pop = adv && !q_status.empty;

  assign dx = $signed({2'b00, job.col, 1'b0}) - $signed({3'b000, cfg.center_x_half});
  assign dy = $signed({2'b00, job.row, 1'b0}) - $signed({3'b000, cfg.center_y_half});

  always_comb begin
    pt_next = '0;
    if (tb.point_valid) begin
      pt_next.point_x   = dtpc_pkg::round_sat(p2x);
      pt_next.point_y   = dtpc_pkg::round_sat(p2y);
      pt_next.point_z   = tb.depth_mm;
      pt_next.out_red   = tb.red;
      pt_next.out_green = tb.green;
      pt_next.out_blue  = tb.blue;
    end
    pt_next.point_valid = tb.point_valid;
    pt_next.frame_end   = tb.frame_end;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ta  <= job.tag;
      p1x <= dtpc_pkg::PROD1_W'(dx) *
             dtpc_pkg::PROD1_W'($signed({1'b0, job.tag.depth_mm}));
      p1y <= dtpc_pkg::PROD1_W'(dy) *
             dtpc_pkg::PROD1_W'($signed({1'b0, job.tag.depth_mm}));
      tb  <= ta;
      p2x <= dtpc_pkg::PROD2_W'(p1x) *
             dtpc_pkg::PROD2_W'($signed({1'b0, cfg.inv_focal_x}));
      p2y <= dtpc_pkg::PROD2_W'(p1y) *
             dtpc_pkg::PROD2_W'($signed({1'b0, cfg.inv_focal_y}));
      pt  <= pt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va       <= 1'b0;
      vb       <= 1'b0;
      pt_valid <= 1'b0;
    end else if (adv) begin
      va       <= !q_status.empty;
      vb       <= va;
      pt_valid <= vb;
    end
  end

  `ASSERT_ALWAYS(a_marker_is_end, (pt_valid && !pt.point_valid) |-> pt.frame_end,
                 "empty result without frame end")
  `ASSERT_ALWAYS(a_marker_zero, (pt_valid && !pt.point_valid) |-> (pt.point_z == '0),
                 "end marker carries depth")

endmodule

// File: rtl/depth_to_point_cloud.sv
// ----------------------------------------------------------------------------
// depth_to_point_cloud
// Pinhole back-projection of aligned depth and colour pixels to 3-D points.
// ----------------------------------------------------------------------------
//  channel | dir | handshake        | payload
//  pix     | in  | valid / stall    | dtpc_pkg::pixel_t
//  pt      | out | valid / stall    | dtpc_pkg::point_t
//  cfg     | in  | valid / ready    | cfg_index, cfg_data
//
//  One pixel per cycle while pix_stall is low. Kept pixels (nonzero depth
//  or frame end) pass the two multiplier stages and the rounding stage.
//  Reset (synchronous) clears the counters and restores the register defaults.
//  A stalled output freezes the back end; the 4-entry queue then fills and
//  pix_stall rises.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module depth_to_point_cloud #(
  parameter int COORD_BITS = 12
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                pix_valid,
  output logic                                pix_stall,
  input  dtpc_pkg::pixel_t                    pix,
  output logic                                pt_valid,
  input  logic                                pt_stall,
  output dtpc_pkg::point_t                    pt,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [dtpc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [dtpc_pkg::CFG_DAT_W-1:0]      cfg_data
);

  dtpc_pkg::cfg_t      cfg;
  dtpc_pkg::q_status_t q_status;
  dtpc_pkg::job_t      push_job, pop_job;
  logic                push, pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.frame_width   <= 13'd640;
      cfg.frame_height  <= 13'd480;
      cfg.center_x_half <= 13'd641;
      cfg.center_y_half <= 13'd481;
      cfg.inv_focal_x   <= 25'd30252;
      cfg.inv_focal_y   <= 25'd30252;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        dtpc_pkg::REG_FRAME_WIDTH:   cfg.frame_width   <= cfg_data[12:0];
        dtpc_pkg::REG_FRAME_HEIGHT:  cfg.frame_height  <= cfg_data[12:0];
        dtpc_pkg::REG_CENTER_X_HALF: cfg.center_x_half <= cfg_data[12:0];
        dtpc_pkg::REG_CENTER_Y_HALF: cfg.center_y_half <= cfg_data[12:0];
        dtpc_pkg::REG_INV_FOCAL_X:   cfg.inv_focal_x   <= cfg_data;
        dtpc_pkg::REG_INV_FOCAL_Y:   cfg.inv_focal_y   <= cfg_data;
        default: ;
      endcase
    end
  end

  dtpc_front #(
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .pix_valid (pix_valid),
    .pix_stall (pix_stall),
    .pix       (pix),
    .cfg       (cfg),
    .q_status  (q_status),
    .push      (push),
    .push_job  (push_job)
  );

  dtpc_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .pop_job  (pop_job),
    .status   (q_status)
  );

  dtpc_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .q_status (q_status),
    .job      (pop_job),
    .pop      (pop),
    .pt_valid (pt_valid),
    .pt_stall (pt_stall),
    .pt       (pt)
  );

endmodule
